/* src/stb_pkg.sv */
// shared types, codes and constants of the software timer bank
package stb_pkg;

   localparam int TIMER_COUNT_DEFAULT = 16;
   localparam int MASK_WIDTH = 16;

   // operation codes
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_REGISTER = 2'd1;
   localparam logic [1:0] OP_SET = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   // reply codes
   localparam logic [1:0] REPLY_STARTED = 2'd0;
   localparam logic [1:0] REPLY_UNCHANGED = 2'd1;
   localparam logic [1:0] REPLY_CLEARED = 2'd2;
   localparam logic [1:0] REPLY_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  timer_index;
      logic [31:0] duration_ms;
      logic [7:0]  tag;
      logic        clear_request;
      logic [7:0]  flag_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  reply_code;
      logic        armed;
      logic [7:0]  owner_tag;
      logic [7:0]  result_flag;
      logic [15:0] expired_mask;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_DRAIN,
      ST_REG_READ,
      ST_REG_EXEC,
      ST_SET,
      ST_LOOKUP,
      ST_RESPOND
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic scan_rd;
      logic reg_exec;
      logic set_exec;
      logic respond_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] operation;
      logic       rsp_busy;
   } status_type;

endpackage

/* src/stb_ctrl.sv */
// sequencing state machine and scan counter of the timer bank
module stb_ctrl #(
   parameter int TIMER_COUNT = stb_pkg::TIMER_COUNT_DEFAULT,
   parameter int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  stb_pkg::ctrl_state_type first_state,
   input  logic                    rsp_busy,
   output stb_pkg::cmd_type        cmd,
   output logic [IW-1:0]           scan_addr
);
   import stb_pkg::*;

   localparam logic [IW-1:0] LAST_ENTRY = IW'(TIMER_COUNT - 1);

   ctrl_state_type state_ff, state_in;
   logic [IW-1:0]  scan_ff, scan_in;

   // state and scan counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

   assign scan_addr = scan_ff;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      scan_in   = scan_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               scan_in     = '0;
               state_in    = ST_DISPATCH;
            end
         end
         // branch on the captured operation
         ST_DISPATCH: state_in = first_state;
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (scan_ff == LAST_ENTRY) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         // last scanned entry is evaluated and written back here
         ST_DRAIN:    state_in = ST_LOOKUP;
         ST_REG_READ: state_in = ST_REG_EXEC;
         ST_REG_EXEC: begin
            cmd.reg_exec = 1'b1;
            state_in     = ST_LOOKUP;
         end
         ST_SET: begin
            cmd.set_exec = 1'b1;
            state_in     = ST_LOOKUP;
         end
         ST_LOOKUP:   state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (!rsp_busy) begin
               cmd.respond_load = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

endmodule

/* src/stb_dispatch.sv */
// picks the first working state for a newly accepted transaction
module stb_dispatch (
   input  logic [1:0]              operation,
   output stb_pkg::ctrl_state_type first_state
);
   import stb_pkg::*;

   // operation decoder
   always_comb begin
      unique case (operation)
         OP_TICK:     first_state = ST_SCAN;
         OP_REGISTER: first_state = ST_REG_READ;
         OP_SET:      first_state = ST_SET;
         OP_QUERY:    first_state = ST_LOOKUP;
         default:     first_state = ST_LOOKUP;
      endcase
   end

endmodule

/* src/stb_datapath.sv */
// timer storage, time counter, update logic and result register
module stb_datapath #(
   parameter int TIMER_COUNT = stb_pkg::TIMER_COUNT_DEFAULT,
   parameter int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  stb_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output stb_pkg::rsp_type    rsp_data,
   input  stb_pkg::cmd_type    cmd,
   input  logic [IW-1:0]       scan_addr,
   output stb_pkg::status_type status
);
   import stb_pkg::*;

   // entry memories, reset values supplied by the valid bits below
   logic [31:0] len_mem   [TIMER_COUNT];
   logic [31:0] start_mem [TIMER_COUNT];
   logic [7:0]  tag_mem   [TIMER_COUNT];
   logic [7:0]  flag_mem  [TIMER_COUNT];

   logic [TIMER_COUNT-1:0] armed_ff, tag_vld_ff, flag_vld_ff, flag_nz_ff;

   req_type     item_ff;
   logic [31:0] time_now_ff;
   logic [1:0]  reply_ff;
   logic [31:0] len_rd_ff, start_rd_ff;
   logic [7:0]  tag_rd_ff, flag_rd_ff;
   logic        eval_ff;
   logic [IW-1:0] eval_idx_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   logic          idx_ok;
   logic [IW-1:0] item_addr, rd_addr, wr_addr;
   logic [7:0]    tag_cur;
   logic          idle, hit;
   logic          len_we, start_we, tag_we, flag_we, armed_we, armed_wd;
   logic [31:0]   len_wd;
   logic [7:0]    flag_wd;
   logic          reply_we;
   logic [1:0]    reply_wd;
   logic [MASK_WIDTH-1:0] mask;
   rsp_type       rsp_next;

   assign idx_ok    = 32'(item_ff.timer_index) < 32'(TIMER_COUNT);
   assign item_addr = IW'(item_ff.timer_index);
   assign rd_addr   = cmd.scan_rd ? scan_addr : item_addr;
   assign wr_addr   = eval_ff ? eval_idx_ff : item_addr;
   assign tag_cur   = tag_vld_ff[item_addr] ? tag_rd_ff : 8'd0;
   assign idle      = !armed_ff[item_addr] || (len_rd_ff == 32'd0);
   assign hit       = eval_ff && armed_ff[eval_idx_ff] &&
                      ((time_now_ff - start_rd_ff) >= len_rd_ff);

   // update decision for scan, register and set transactions
   always_comb begin
      len_we   = 1'b0;
      start_we = 1'b0;
      tag_we   = 1'b0;
      flag_we  = 1'b0;
      armed_we = 1'b0;
      armed_wd = 1'b0;
      len_wd   = item_ff.duration_ms;
      flag_wd  = 8'd0;
      reply_we = 1'b0;
      reply_wd = REPLY_UNCHANGED;
      if (hit) begin
         flag_we = 1'b1;
         flag_wd = 8'd1;
      end
      if (cmd.reg_exec && idx_ok) begin
         reply_we = 1'b1;
         if (idle || (!item_ff.clear_request && item_ff.tag != 8'd0 &&
                      item_ff.tag != tag_cur)) begin
            reply_wd = REPLY_STARTED;
            len_we   = 1'b1;
            start_we = 1'b1;
            tag_we   = 1'b1;
            flag_we  = 1'b1;
            armed_we = 1'b1;
            armed_wd = 1'b1;
         end else if (item_ff.clear_request) begin
            reply_wd = REPLY_CLEARED;
            len_we   = 1'b1;
            len_wd   = 32'd0;
            start_we = 1'b1;
            flag_we  = 1'b1;
            armed_we = 1'b1;
         end
      end
      if (cmd.set_exec && idx_ok) begin
         flag_we = 1'b1;
         flag_wd = item_ff.flag_value;
      end
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (len_we)   len_mem[wr_addr]   <= len_wd;
      if (start_we) start_mem[wr_addr] <= time_now_ff;
      if (tag_we)   tag_mem[wr_addr]   <= item_ff.tag;
      if (flag_we)  flag_mem[wr_addr]  <= flag_wd;
      len_rd_ff   <= len_mem[rd_addr];
      start_rd_ff <= start_mem[rd_addr];
      tag_rd_ff   <= tag_mem[rd_addr];
      flag_rd_ff  <= flag_mem[rd_addr];
      eval_idx_ff <= scan_addr;
   end

   // per-entry bits, time counter and scan pipeline flag
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff    <= '0;
         tag_vld_ff  <= '0;
         flag_vld_ff <= '0;
         flag_nz_ff  <= '0;
         time_now_ff <= '0;
         eval_ff     <= 1'b0;
      end else begin
         eval_ff <= cmd.scan_rd;
         if (armed_we) armed_ff[wr_addr] <= armed_wd;
         if (tag_we)   tag_vld_ff[wr_addr] <= 1'b1;
         if (flag_we) begin
            flag_vld_ff[wr_addr] <= 1'b1;
            flag_nz_ff[wr_addr]  <= flag_wd != 8'd0;
         end
         if (cmd.capture && req_data.operation == OP_TICK) begin
            time_now_ff <= time_now_ff + 32'd1;
         end
      end
   end

   // captured transaction and reply code
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff  <= req_data;
         reply_ff <= (req_data.operation == OP_REGISTER) ? REPLY_UNCHANGED : REPLY_NONE;
      end else if (reply_we) begin
         reply_ff <= reply_wd;
      end
   end

   // expired mask over the addressable timers
   for (genvar g = 0; g < MASK_WIDTH; g++) begin : g_mask
      if (g < TIMER_COUNT) begin : g_live
         assign mask[g] = flag_nz_ff[g];
      end else begin : g_none
         assign mask[g] = 1'b0;
      end
   end

   // result assembly
   always_comb begin
      rsp_next              = '0;
      rsp_next.reply_code   = reply_ff;
      rsp_next.expired_mask = mask;
      if (idx_ok) begin
         rsp_next.armed       = armed_ff[item_addr];
         rsp_next.owner_tag   = tag_cur;
         rsp_next.result_flag = flag_vld_ff[item_addr] ? flag_rd_ff : 8'd0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond_load) rsp_ff <= rsp_next;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;
   assign status.operation   = item_ff.operation;
   assign status.rsp_busy    = rsp_valid_ff && rsp_stall;

endmodule

/* src/stb_ctrl_top.sv */
// controller wrapper joining the state machine with the operation decoder
module stb_ctrl_top #(
   parameter int TIMER_COUNT = stb_pkg::TIMER_COUNT_DEFAULT,
   parameter int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  stb_pkg::status_type status,
   output stb_pkg::cmd_type    cmd,
   output logic [IW-1:0]       scan_addr
);
   import stb_pkg::*;

   ctrl_state_type first_state;

   // operation decoder
   stb_dispatch u_dispatch (
      .operation   (status.operation),
      .first_state (first_state)
   );

   // sequencing state machine
   stb_ctrl #(
      .TIMER_COUNT (TIMER_COUNT),
      .IW          (IW)
   ) u_fsm (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .first_state (first_state),
      .rsp_busy    (status.rsp_busy),
      .cmd         (cmd),
      .scan_addr   (scan_addr)
   );

endmodule

/* src/software_timer_bank.sv */
// top level of the software timer bank
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  stb_pkg::req_type
//  rsp      out        rsp_valid/rsp_stall  stb_pkg::rsp_type
//
// a tick scans every timer entry from acceptance until its result can be
// taken: the scan reads one timer entry per cycle through the single read port.
// register, set and query skip the scan; the next transaction is taken
// once the result sits in the output register, even while it is stalled.
// reset is synchronous and clears the time counter and all per-timer bits
// at once, so no clearing pass follows it.
module software_timer_bank #(
   parameter int TIMER_COUNT = stb_pkg::TIMER_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stb_pkg::rsp_type rsp_data
);
   import stb_pkg::*;

   localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

   cmd_type       cmd;
   status_type    status;
   logic [IW-1:0] scan_addr;

   // sequencer
   stb_ctrl_top #(
      .TIMER_COUNT (TIMER_COUNT),
      .IW          (IW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .scan_addr (scan_addr)
   );

   // storage and update datapath
   stb_datapath #(
      .TIMER_COUNT (TIMER_COUNT),
      .IW          (IW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .scan_addr (scan_addr),
      .status    (status)
   );

endmodule

/* dv/software_timer_bank_tb.sv */
// self-checking testbench for the software timer bank, with a built-in timer predictor
`timescale 1ns / 1ps

module software_timer_bank_tb;
   import stb_pkg::*;

   localparam int BANK_SIZE = TIMER_COUNT_DEFAULT;
   localparam int QUIET_TAIL = 200;
   localparam int PRESSURE_AFTER = 400;
   localparam int PRESSURE_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 1500;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // timer bank image kept by the predictor
   logic [31:0] bank_time;
   logic [31:0] bank_length [BANK_SIZE];
   logic [31:0] bank_start [BANK_SIZE];
   logic [7:0]  bank_flag [BANK_SIZE];
   logic        bank_armed [BANK_SIZE];
   logic [7:0]  bank_tag [BANK_SIZE];

   req_type pending_requests [$];
   rsp_type expected_replies [$];

   logic req_taken = 1'b0;
   int   total_items = 0;
   int   replies_seen = 0;
   int   mismatch_count = 0;
   int   cycle_count = 0;
   int   quiet_cycles = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   bit   pressure_done = 1'b0;

   software_timer_bank dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // applies one transaction to the bank image and returns the reply it should give
   function automatic rsp_type timer_bank_step(input req_type item);
      rsp_type     reply;
      int          t;
      logic        restart;
      logic [31:0] elapsed;
      reply = '0;
      reply.reply_code = REPLY_NONE;
      restart = 1'b0;
      t = item.timer_index;
      case (item.operation)
         OP_TICK: begin
            bank_time = bank_time + 32'd1;
            for (int i = 0; i < BANK_SIZE; i++) begin
               elapsed = bank_time - bank_start[i];
               if (bank_armed[i] && elapsed >= bank_length[i]) bank_flag[i] = 8'd1;
            end
         end
         OP_REGISTER: begin
            // an idle timer starts whatever the clear request says
            if (bank_length[t] == 32'd0) begin
               restart = 1'b1;
            end else if (item.clear_request) begin
               bank_length[t] = 32'd0;
               bank_flag[t] = 8'd0;
               bank_armed[t] = 1'b0;
               bank_start[t] = bank_time;
               reply.reply_code = REPLY_CLEARED;
            end else if (item.tag != 8'd0 && item.tag != bank_tag[t]) begin
               restart = 1'b1;
            end else begin
               reply.reply_code = REPLY_UNCHANGED;
            end
            if (restart) begin
               bank_length[t] = item.duration_ms;
               bank_start[t] = bank_time;
               bank_flag[t] = 8'd0;
               bank_armed[t] = 1'b1;
               bank_tag[t] = item.tag;
               reply.reply_code = REPLY_STARTED;
            end
         end
         OP_SET: bank_flag[t] = item.flag_value;
         default: ;
      endcase
      reply.armed = bank_armed[t];
      reply.owner_tag = bank_tag[t];
      reply.result_flag = bank_flag[t];
      for (int i = 0; i < BANK_SIZE && i < MASK_WIDTH; i++)
         reply.expired_mask[i] = (bank_flag[i] != 8'd0);
      return reply;
   endfunction

   function automatic req_type timer_item(input logic [1:0] op, input logic [3:0] index,
                                          input logic [31:0] duration, input logic [7:0] tag,
                                          input logic clear, input logic [7:0] flag);
      req_type item;
      item.operation = op;
      item.timer_index = index;
      item.duration_ms = duration;
      item.tag = tag;
      item.clear_request = clear;
      item.flag_value = flag;
      return item;
   endfunction

   // short durations and a handful of tags so that expiries, restarts and clashes are frequent
   function automatic req_type random_timer_item();
      req_type item;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) item.operation = OP_TICK;
      else if (pick < 70) item.operation = OP_REGISTER;
      else if (pick < 80) item.operation = OP_SET;
      else item.operation = OP_QUERY;
      item.timer_index = 4'($urandom_range(0, BANK_SIZE - 1));
      pick = $urandom_range(0, 9);
      if (pick < 7) item.duration_ms = $urandom_range(0, 12);
      else if (pick < 9) item.duration_ms = $urandom_range(0, 200);
      else item.duration_ms = $urandom;
      item.tag = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      item.clear_request = ($urandom_range(0, 3) == 0);
      item.flag_value = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
      return item;
   endfunction

   // transaction driver, inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap != 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            req_data <= pending_requests.pop_front();
            req_valid <= 1'b1;
            if (cycle_count[9] == 1'b0 && pending_requests.size() > QUIET_TAIL &&
                $urandom_range(0, 5) == 0)
               send_gap = $urandom_range(1, 16);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure: random bursts plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!pressure_done && replies_seen >= PRESSURE_AFTER) begin
            hold_left = PRESSURE_CYCLES;
            pressure_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (cycle_count[10:9] != 2'b11 && replies_seen + QUIET_TAIL < total_items &&
                      $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor: predict on each accepted request, check each accepted reply
   always @(posedge clock) begin
      rsp_type wanted;
      cycle_count = cycle_count + 1;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) expected_replies.push_back(timer_bank_step(req_data));
         if (rsp_valid && !rsp_stall) begin
            replies_seen = replies_seen + 1;
            if (expected_replies.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("unexpected reply: code %0d armed %0d tag %h flag %h mask %h",
                           rsp_data.reply_code, rsp_data.armed, rsp_data.owner_tag,
                           rsp_data.result_flag, rsp_data.expired_mask);
            end else begin
               wanted = expected_replies.pop_front();
               if (rsp_data !== wanted) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10) begin
                     $display("reply %0d mismatch: expected code %0d armed %0d tag %h flag %h",
                              replies_seen, wanted.reply_code, wanted.armed,
                              wanted.owner_tag, wanted.result_flag);
                     $display("   expected mask %h, got code %0d armed %0d tag %h flag %h",
                              wanted.expired_mask, rsp_data.reply_code, rsp_data.armed,
                              rsp_data.owner_tag, rsp_data.result_flag);
                     $display("   got mask %h", rsp_data.expired_mask);
                  end
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      bank_time = '0;
      for (int i = 0; i < BANK_SIZE; i++) begin
         bank_length[i] = '0;
         bank_start[i] = '0;
         bank_flag[i] = '0;
         bank_armed[i] = 1'b0;
         bank_tag[i] = '0;
      end

      // directed: reset state, zero duration, restart rules, clearing, flag overwrites
      pending_requests.push_back(timer_item(OP_QUERY, 4'd0, 32'd0, 8'd0, 1'b0, 8'd0));
      pending_requests.push_back(timer_item(OP_REGISTER, 4'd0, 32'd0, 8'h00, 1'b1, 8'd0));
      pending_requests.push_back(timer_item(OP_TICK, 4'd0, 32'd0, 8'd0, 1'b0, 8'd0));
      pending_requests.push_back(timer_item(OP_REGISTER, 4'd0, 32'd3, 8'hAA, 1'b0, 8'd0));
      pending_requests.push_back(timer_item(OP_REGISTER, 4'd0, 32'd9, 8'hAA, 1'b0, 8'd0));
      pending_requests.push_back(timer_item(OP_REGISTER, 4'd0, 32'd9, 8'h00, 1'b0, 8'd0));
      pending_requests.push_back(timer_item(OP_REGISTER, 4'd0, 32'd2, 8'h55, 1'b0, 8'd0));
      pending_requests.push_back(timer_item(OP_TICK, 4'd0, 32'd0, 8'd0, 1'b0, 8'd0));
      pending_requests.push_back(timer_item(OP_TICK, 4'd15, 32'd0, 8'd0, 1'b0, 8'd0));
      pending_requests.push_back(timer_item(OP_SET, 4'd15, 32'd0, 8'd0, 1'b0, 8'hFF));
      pending_requests.push_back(timer_item(OP_QUERY, 4'd15, 32'hFFFF_FFFF, 8'hFF, 1'b1, 8'hFF));
      pending_requests.push_back(timer_item(OP_REGISTER, 4'd15, 32'hFFFF_FFFF, 8'hFF, 1'b0,
                                            8'hFF));
      pending_requests.push_back(timer_item(OP_SET, 4'd0, 32'd0, 8'd0, 1'b0, 8'hFE));
      pending_requests.push_back(timer_item(OP_SET, 4'd15, 32'd0, 8'd0, 1'b0, 8'h80));
      pending_requests.push_back(timer_item(OP_TICK, 4'd0, 32'd0, 8'd0, 1'b0, 8'd0));
      pending_requests.push_back(timer_item(OP_REGISTER, 4'd0, 32'd5, 8'h55, 1'b1, 8'd0));
      pending_requests.push_back(timer_item(OP_QUERY, 4'd0, 32'd0, 8'd0, 1'b0, 8'd0));
      pending_requests.push_back(timer_item(OP_REGISTER, 4'd0, 32'd1, 8'h00, 1'b1, 8'd0));
      pending_requests.push_back(timer_item(OP_REGISTER, 4'd15, 32'd0, 8'hFF, 1'b1, 8'd0));
      pending_requests.push_back(timer_item(OP_TICK, 4'd7, 32'd0, 8'd0, 1'b0, 8'd0));
      pending_requests.push_back(timer_item(OP_SET, 4'd7, 32'd0, 8'd0, 1'b0, 8'h01));
      pending_requests.push_back(timer_item(OP_SET, 4'd0, 32'd0, 8'd0, 1'b0, 8'h00));
      pending_requests.push_back(timer_item(OP_QUERY, 4'd7, 32'd0, 8'd0, 1'b0, 8'd0));
      for (int i = 0; i < RANDOM_ITEMS; i++) pending_requests.push_back(random_timer_item());
      total_items = pending_requests.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // drain, then allow for a tick's full scan before judging
      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (4 * BANK_SIZE) @(posedge clock);
      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
